// ===== sv/rgv_pkg.sv =====
// Shared types, constants and helper functions of the rotated grid view.
package rgv_pkg;

  localparam int MAX_DIM    = 16;
  localparam int POS_W      = 5;
  localparam int DIM_W      = $clog2(MAX_DIM + 1);
  localparam int CW         = $clog2(MAX_DIM);
  localparam int GAW        = 2 * CW;
  localparam int GRID_N     = MAX_DIM * MAX_DIM;
  localparam int DIAG_N     = 2 * MAX_DIM - 1;
  localparam int DAW        = $clog2(DIAG_N);
  localparam int ROT_W      = 4;
  localparam int CHAR_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROTATION  = 2'd2;

  localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;

  typedef logic [MAX_DIM-1:0] lane_mask_t;

  typedef struct packed {
    logic              grid_we;
    logic [GAW-1:0]    grid_addr;
    logic [DAW-1:0]    anti_addr;
    logic [DAW-1:0]    diag_addr;
    logic [CW-1:0]     col;
    logic [CHAR_W-1:0] value;
  } mem_req_t;

  typedef struct packed {
    logic       outside;
    logic       filled;
    logic       plain_end;
    logic       half;
    logic       use_diag;
    lane_mask_t check;
  } view_t;

  function automatic logic is_nonblank(input logic [CHAR_W-1:0] b);
    is_nonblank = !((b == CHAR_NUL) || (b == CHAR_SPACE) ||
                    ((b >= CHAR_TAB) && (b <= CHAR_CR)));
  endfunction

  function automatic logic [CHAR_W-1:0] printed(input logic [CHAR_W-1:0] b);
    printed = (b == CHAR_NUL) ? CHAR_SPACE : b;
  endfunction

endpackage

// ===== sv/rgv_map.sv =====
// Position mapping: view classification, store addresses and the line-end lane mask.
module rgv_map (
  input  logic                         kind,
  input  logic [rgv_pkg::POS_W-1:0]    row_pos,
  input  logic [rgv_pkg::POS_W-1:0]    col_pos,
  input  logic [rgv_pkg::CHAR_W-1:0]   cell_value,
  input  logic [rgv_pkg::DIM_W-1:0]    row_count,
  input  logic [rgv_pkg::DIM_W-1:0]    col_count,
  input  logic [rgv_pkg::ROT_W-1:0]    rotation_steps,
  output rgv_pkg::mem_req_t            req,
  output rgv_pkg::view_t               view
);

  localparam int AW = rgv_pkg::POS_W + 2;

  function automatic logic [rgv_pkg::DIM_W-1:0] clamp_dim(
    input logic [rgv_pkg::DIM_W-1:0] v
  );
    if (v == '0) begin
      clamp_dim = rgv_pkg::DIM_W'(1);
    end else if (v > rgv_pkg::DIM_W'(rgv_pkg::MAX_DIM)) begin
      clamp_dim = rgv_pkg::DIM_W'(rgv_pkg::MAX_DIM);
    end else begin
      clamp_dim = v;
    end
  endfunction

  logic [rgv_pkg::DIM_W-1:0] dim_r, dim_c, r2, c2;
  logic [1:0]                q;
  logic                      half;
  logic [AW-1:0]             i, j, n, rm1, sum, x2, y2, xs, ys, orow_w, ocol_w;
  logic [AW-1:0]             kk, d7, r7, c7;
  logic                      plain_out, dia_out, dia_empty, in_range, on_line, after;
  logic [rgv_pkg::CW-1:0]    orow, ocol;
  logic [rgv_pkg::DAW-1:0]   anti, diag;

  always_comb begin
    dim_r = clamp_dim(row_count);
    dim_c = clamp_dim(col_count);
    q     = rotation_steps[2:1];
    half  = rotation_steps[0];
    r2    = q[0] ? dim_c : dim_r;
    c2    = q[0] ? dim_r : dim_c;
    r7    = AW'(dim_r);
    c7    = AW'(dim_c);
    i     = AW'(row_pos);
    j     = AW'(col_pos);
    rm1   = AW'(r2) - AW'(1);
    n     = AW'(r2) + AW'(c2) - AW'(1);
    sum   = i + j;
    y2    = (sum - rm1) >> 1;
    x2    = (i + rm1 - j) >> 1;

    plain_out = (i >= AW'(r2)) || (j >= AW'(c2));
    dia_out   = (i >= n) || (j >= n);
    dia_empty = sum[0] ^ rm1[0] || (sum < rm1) || ((i + rm1) < j) ||
                (x2 >= AW'(r2)) || (y2 >= AW'(c2));

    xs = half ? x2 : i;
    ys = half ? y2 : j;
    case (q)
      2'd0: begin
        orow_w = xs;
        ocol_w = ys;
      end
      2'd1: begin
        orow_w = r7 - AW'(1) - ys;
        ocol_w = xs;
      end
      2'd2: begin
        orow_w = r7 - AW'(1) - xs;
        ocol_w = c7 - AW'(1) - ys;
      end
      default: begin
        orow_w = ys;
        ocol_w = c7 - AW'(1) - xs;
      end
    endcase

    if (kind == rgv_pkg::KIND_WRITE) begin
      orow = row_pos[rgv_pkg::CW-1:0];
      ocol = col_pos[rgv_pkg::CW-1:0];
    end else begin
      orow = orow_w[rgv_pkg::CW-1:0];
      ocol = ocol_w[rgv_pkg::CW-1:0];
    end
    in_range = (row_pos < rgv_pkg::POS_W'(rgv_pkg::MAX_DIM)) &&
               (col_pos < rgv_pkg::POS_W'(rgv_pkg::MAX_DIM));
    anti = rgv_pkg::DAW'(orow) + rgv_pkg::DAW'(ocol);
    diag = rgv_pkg::DAW'(ocol) + rgv_pkg::DAW'(rgv_pkg::MAX_DIM - 1) - rgv_pkg::DAW'(orow);

    req.grid_we   = (kind == rgv_pkg::KIND_WRITE) && in_range;
    req.grid_addr = {orow, ocol};
    req.anti_addr = anti;
    req.diag_addr = diag;
    req.col       = ocol;
    req.value     = cell_value;

    view.outside   = half ? dia_out : plain_out;
    view.filled    = !view.outside && !(half && dia_empty);
    view.plain_end = (j == AW'(c2) - AW'(1));
    view.half      = half;
    view.use_diag  = q[0];

    // later cells of the same output line, as columns of the stored grid
    d7 = q[0] ? AW'(diag) : AW'(anti);
    for (int k = 0; k < rgv_pkg::MAX_DIM; k++) begin
      kk = AW'(k);
      if (q[0]) begin
        on_line = (kk + AW'(rgv_pkg::MAX_DIM - 1) >= d7) &&
                  (kk + AW'(rgv_pkg::MAX_DIM - 1) < d7 + r7);
      end else begin
        on_line = (kk <= d7) && (kk + r7 > d7);
      end
      after = (q == 2'd0 || q == 2'd3) ? (kk > AW'(ocol)) : (kk < AW'(ocol));
      view.check[k] = (kk < c7) && on_line && after;
    end
  end

endmodule

// ===== sv/rgv_store.sv =====
// Grid memory and the two diagonal blank-mask memories with read-modify-write and forwarding.
module rgv_store (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  rgv_pkg::mem_req_t           req,
  output logic [rgv_pkg::CHAR_W-1:0]  grid_q,
  output rgv_pkg::lane_mask_t         anti_q,
  output rgv_pkg::lane_mask_t         diag_q
);

  logic [rgv_pkg::CHAR_W-1:0] grid_mem [rgv_pkg::GRID_N];
  rgv_pkg::lane_mask_t        anti_mem [rgv_pkg::DIAG_N];
  rgv_pkg::lane_mask_t        diag_mem [rgv_pkg::DIAG_N];

  logic [rgv_pkg::CHAR_W-1:0] grid_rd;
  rgv_pkg::lane_mask_t        anti_rd, diag_rd, anti_new, diag_new, fw_anti, fw_diag;
  logic                       wr_s1, fw_valid, nb1;
  logic [rgv_pkg::DAW-1:0]    anti_a1, diag_a1, fw_anti_addr, fw_diag_addr;
  logic [rgv_pkg::CW-1:0]     col1;

  // grid write at accept, registered reads
  always_ff @(posedge clk) begin
    if (accept && req.grid_we) begin
      grid_mem[req.grid_addr] <= req.value;
    end
    grid_rd <= grid_mem[req.grid_addr];
    anti_rd <= anti_mem[req.anti_addr];
    diag_rd <= diag_mem[req.diag_addr];
  end

  // write back modified masks in the cycle after the request
  always_ff @(posedge clk) begin
    if (wr_s1) begin
      anti_mem[anti_a1] <= anti_new;
      diag_mem[diag_a1] <= diag_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_s1    <= 1'b0;
      fw_valid <= 1'b0;
    end else begin
      wr_s1    <= accept && req.grid_we;
      fw_valid <= wr_s1;
    end
    anti_a1      <= req.anti_addr;
    diag_a1      <= req.diag_addr;
    col1         <= req.col;
    nb1          <= rgv_pkg::is_nonblank(req.value);
    fw_anti_addr <= anti_a1;
    fw_diag_addr <= diag_a1;
    fw_anti      <= anti_new;
    fw_diag      <= diag_new;
  end

  always_comb begin
    grid_q   = grid_rd;
    anti_q   = (fw_valid && fw_anti_addr == anti_a1) ? fw_anti : anti_rd;
    diag_q   = (fw_valid && fw_diag_addr == diag_a1) ? fw_diag : diag_rd;
    anti_new = anti_q;
    diag_new = diag_q;
    anti_new[col1] = nb1;
    diag_new[col1] = nb1;
  end

endmodule

// ===== sv/rotated_grid_view_45_steps_unit.sv =====
// Top level of the rotated grid view: configuration, pipeline and result register.
// A read shows its word on the result ports via the s1 and result registers; writes give none.
// Throughput: one word per cycle, busy stays low; a stored cell is one grid memory read,
// and half-step line ends come from one diagonal blank-mask read, rewritten after each write.
// Reset: rst clears the pipeline and sets row_count 1, col_count 1, rotation_steps 0;
// the memories hold undefined data until written. The receiver cannot stall.
module rotated_grid_view_45_steps_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic                             kind,
  input  logic [rgv_pkg::POS_W-1:0]        row_pos,
  input  logic [rgv_pkg::POS_W-1:0]        col_pos,
  input  logic [rgv_pkg::CHAR_W-1:0]       cell_value,
  input  logic                             cfg_write,
  input  logic [rgv_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rgv_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                             done,
  output logic [rgv_pkg::CHAR_W-1:0]       out_char,
  output logic                             is_filled,
  output logic                             line_end,
  output logic                             outside
);

  logic [rgv_pkg::DIM_W-1:0]  row_count, col_count;
  logic [rgv_pkg::ROT_W-1:0]  rotation_steps;
  logic                       accept, s1_valid;
  rgv_pkg::mem_req_t          req;
  rgv_pkg::view_t             view, s1_view;
  logic [rgv_pkg::CHAR_W-1:0] grid_q, char_next;
  rgv_pkg::lane_mask_t        anti_q, diag_q, lane_sel;
  logic                       filled_next, end_next, outside_next;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count      <= rgv_pkg::DIM_W'(1);
      col_count      <= rgv_pkg::DIM_W'(1);
      rotation_steps <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        rgv_pkg::CFG_ROW_COUNT: row_count      <= cfg_data[rgv_pkg::DIM_W-1:0];
        rgv_pkg::CFG_COL_COUNT: col_count      <= cfg_data[rgv_pkg::DIM_W-1:0];
        rgv_pkg::CFG_ROTATION:  rotation_steps <= cfg_data[rgv_pkg::ROT_W-1:0];
        default: ;
      endcase
    end
  end

  rgv_map u_map (
    .kind           (kind),
    .row_pos        (row_pos),
    .col_pos        (col_pos),
    .cell_value     (cell_value),
    .row_count      (row_count),
    .col_count      (col_count),
    .rotation_steps (rotation_steps),
    .req            (req),
    .view           (view)
  );

  rgv_store u_store (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .req    (req),
    .grid_q (grid_q),
    .anti_q (anti_q),
    .diag_q (diag_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept && (kind == rgv_pkg::KIND_READ);
    end
    s1_view <= view;
  end

  always_comb begin
    lane_sel = s1_view.use_diag ? diag_q : anti_q;
    if (s1_view.outside) begin
      char_next    = rgv_pkg::CHAR_NUL;
      filled_next  = 1'b0;
      end_next     = 1'b0;
      outside_next = 1'b1;
    end else if (!s1_view.filled) begin
      char_next    = rgv_pkg::CHAR_SPACE;
      filled_next  = 1'b0;
      end_next     = 1'b0;
      outside_next = 1'b0;
    end else begin
      char_next    = rgv_pkg::printed(grid_q);
      filled_next  = 1'b1;
      end_next     = s1_view.half ?
                     (rgv_pkg::is_nonblank(grid_q) && ((lane_sel & s1_view.check) == '0)) :
                     s1_view.plain_end;
      outside_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s1_valid;
    end
    out_char  <= char_next;
    is_filled <= filled_next;
    line_end  <= end_next;
    outside   <= outside_next;
  end

endmodule

// ===== sv/rgv_check.sv =====
// Port-level checker of the rotated grid view and its bind to the top level.
module rgv_check (
  input logic                         clk,
  input logic                         rst,
  input logic                         start,
  input logic                         busy,
  input logic                         kind,
  input logic                         done,
  input logic [rgv_pkg::CHAR_W-1:0]   out_char,
  input logic                         is_filled,
  input logic                         line_end,
  input logic                         outside
);

  a_outside_word: assert property (@(posedge clk) disable iff (rst)
    done && outside |-> out_char == rgv_pkg::CHAR_NUL && !is_filled && !line_end)
    else $error("outside word carries data");

  a_empty_word: assert property (@(posedge clk) disable iff (rst)
    done && !outside && !is_filled |-> out_char == rgv_pkg::CHAR_SPACE && !line_end)
    else $error("empty diamond word is not a plain space");

  a_end_filled: assert property (@(posedge clk) disable iff (rst)
    done && line_end |-> is_filled)
    else $error("line end on an unfilled cell");

  a_read_done: assert property (@(posedge clk) disable iff (rst)
    start && !busy && kind == rgv_pkg::KIND_READ |-> ##2 done)
    else $error("read gave no word");

  a_done_read: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy && kind == rgv_pkg::KIND_READ, 2))
    else $error("word without a read");

endmodule

bind rotated_grid_view_45_steps_unit rgv_check u_rgv_check (.*);
